### rtl/coil_winding_step_sequencer_defines.svh
// assertion macros for the coil winding step sequencer
// no dependencies; included by modules that carry assertions
`ifndef COIL_WINDING_STEP_SEQUENCER_DEFINES_SVH
`define COIL_WINDING_STEP_SEQUENCER_DEFINES_SVH

// implication checked in the same cycle, quiet during reset
`define CWSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cwss: check failed");

// implication checked in the following cycle, quiet during reset
`define CWSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cwss: check failed");

`endif

### rtl/cwss_pkg.sv
// types and constants shared by the coil winding step sequencer
// no dependencies
package cwss_pkg;

    localparam int unsigned TURNS_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TURNS_TARGET       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSE_STEPS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNS_PER_REVERSAL = 2'd2;

    // traverse step count ceiling
    localparam logic [COUNT_W-1:0] TRAVERSE_STEPS_MAX = 8'd254;

    // status codes
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_HOMING  = 2'd1;
    localparam logic [1:0] ST_WINDING = 2'd2;
    localparam logic [1:0] ST_FAULT   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HOME,
        PH_SPIN,
        PH_TRAV,
        PH_FAULT
    } t_phase;

    typedef struct packed {
        logic [TURNS_W-1:0] turns_target;
        logic [COUNT_W-1:0] traverse_steps;
        logic [TURNS_W-1:0] turns_per_reversal;
    } t_cfg;

    typedef struct packed {
        logic func;
        logic home_switch;
        logic fault_x;
        logic fault_r;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic [TURNS_W-1:0] remaining_turns;
        logic [COUNT_W-1:0] spindle_count;
        logic [COUNT_W-1:0] traverse_count;
        logic [TURNS_W-1:0] reversal_count;
        logic               direction;
    } t_state;

    typedef struct packed {
        logic               spindle_step;
        logic               traverse_step;
        logic               traverse_dir;
        logic [TURNS_W-1:0] turns_left;
        logic [1:0]         status;
        logic               finished;
    } t_result;

endpackage

### rtl/cwss_cfg.sv
// configuration registers of the coil winding step sequencer
// depends on cwss_pkg
module cwss_cfg import cwss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg             r_cfg;
    logic [COUNT_W-1:0] w_steps_in;

    // traverse steps saturate below the all-ones value
    assign w_steps_in = (i_cfg_data[COUNT_W-1:0] > TRAVERSE_STEPS_MAX) ?
                        TRAVERSE_STEPS_MAX : i_cfg_data[COUNT_W-1:0];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TURNS_TARGET:       r_cfg.turns_target <= i_cfg_data[TURNS_W-1:0];
                CFG_TRAVERSE_STEPS:     r_cfg.traverse_steps <= w_steps_in;
                CFG_TURNS_PER_REVERSAL: r_cfg.turns_per_reversal <= i_cfg_data[TURNS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/cwss_step.sv
// next-state and result logic for one word of the step sequencer
// depends on cwss_pkg
module cwss_step import cwss_pkg::*; #(
    parameter int unsigned STEPS_PER_TURN = 199
) (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    localparam logic [COUNT_W-1:0] SPT = COUNT_W'(STEPS_PER_TURN);

    logic               w_fault;
    logic               w_home;
    logic [COUNT_W-1:0] w_sc_dec;
    logic [COUNT_W-1:0] w_tc_inc;
    logic [TURNS_W-1:0] w_rc_inc;
    logic               w_turn_done;
    logic               w_trav_done;
    logic               w_reverse;
    t_phase             n_phase;

    assign w_fault     = i_item.fault_x | i_item.fault_r;
    assign w_home      = i_item.home_switch;
    assign w_sc_dec    = i_state.spindle_count - COUNT_W'(1);
    assign w_tc_inc    = i_state.traverse_count + COUNT_W'(1);
    assign w_rc_inc    = i_state.reversal_count + TURNS_W'(1);
    assign w_turn_done = (w_sc_dec == '0);
    assign w_trav_done = (w_tc_inc > i_cfg.traverse_steps);
    assign w_reverse   = (i_cfg.turns_per_reversal != '0) &&
                         (w_rc_inc == i_cfg.turns_per_reversal);

    // next phase
    always_comb begin
        n_phase = i_state.phase;
        if (w_fault) begin
            n_phase = PH_FAULT;
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_item.func) begin
                        if (!w_home) begin
                            n_phase = PH_HOME;
                        end else if (i_cfg.turns_target != '0) begin
                            n_phase = PH_SPIN;
                        end
                    end
                end
                PH_HOME: begin
                    if (w_home) begin
                        n_phase = (i_state.remaining_turns == '0) ? PH_IDLE : PH_SPIN;
                    end
                end
                PH_SPIN: begin
                    if (w_turn_done) begin
                        n_phase = PH_TRAV;
                    end
                end
                PH_TRAV: begin
                    if (w_trav_done) begin
                        n_phase = (i_state.remaining_turns == '0) ? PH_IDLE : PH_SPIN;
                    end
                end
                default: n_phase = PH_FAULT;
            endcase
        end
    end

    // counters, pulses and result word
    always_comb begin
        o_state       = i_state;
        o_state.phase = n_phase;
        o_result      = '0;
        if (w_fault || i_state.phase == PH_FAULT) begin
            o_state.remaining_turns = '0;
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_item.func) begin
                        o_state.remaining_turns = i_cfg.turns_target;
                        o_state.spindle_count   = SPT;
                        o_state.traverse_count  = '0;
                        o_state.reversal_count  = '0;
                        o_state.direction       = !w_home;
                        o_result.finished       = w_home && (i_cfg.turns_target == '0);
                    end
                end
                PH_HOME: begin
                    if (!w_home) begin
                        o_result.traverse_step = 1'b1;
                    end else begin
                        o_state.direction = 1'b0;
                        o_result.finished = (i_state.remaining_turns == '0);
                    end
                end
                PH_SPIN: begin
                    o_result.spindle_step = 1'b1;
                    if (w_turn_done) begin
                        o_state.remaining_turns = i_state.remaining_turns - TURNS_W'(1);
                        o_state.spindle_count   = SPT;
                        o_state.traverse_count  = '0;
                    end else begin
                        o_state.spindle_count = w_sc_dec;
                    end
                end
                PH_TRAV: begin
                    o_result.traverse_step = 1'b1;
                    if (w_trav_done) begin
                        o_state.traverse_count = '0;
                        o_state.reversal_count = w_reverse ? '0 : w_rc_inc;
                        o_state.direction      = i_state.direction ^ w_reverse;
                        o_result.finished      = (i_state.remaining_turns == '0);
                    end else begin
                        o_state.traverse_count = w_tc_inc;
                    end
                end
                default: o_state.remaining_turns = '0;
            endcase
        end
        o_result.traverse_dir = o_state.direction;
        o_result.turns_left   = o_state.remaining_turns;
        case (n_phase)
            PH_FAULT: o_result.status = ST_FAULT;
            PH_HOME:  o_result.status = ST_HOMING;
            PH_SPIN:  o_result.status = ST_WINDING;
            PH_TRAV:  o_result.status = ST_WINDING;
            default:  o_result.status = ST_IDLE;
        endcase
    end

endmodule

### rtl/coil_winding_step_sequencer.sv
// Coil winding step sequencer: drives the spindle and traverse step motors
// of a coil winder, one pulse slot per input word.
//
// Input channel: i_valid / o_stall carry one word (func, home switch and
// two fault bits). A word is taken at an edge with i_valid high and o_stall
// low. func 0 is a pulse tick, func 1 starts a run (homing, then winding).
// Output channel: o_valid / i_stall carry one result word per input word:
// step pulses, direction, turns left, status and a finished flag.
// Configuration: i_cfg_we writes register i_cfg_idx (0 turns target,
// 1 traverse steps, 2 turns per reversal); the user must write only while
// no word is in flight, the block itself does not enforce it.
// A word is held in the input register, its result in the output register.
// Throughput: one word per cycle while the output is not stalled; the
// sequencing state advances in a single pass of logic between the input
// and output registers. A stall on the output holds the result word; the
// input register keeps taking a word until it is full, then o_stall rises.
// Reset (synchronous, active low) clears the valid flags, the configuration,
// the run state and the fault latch; a latched fault stays until the next reset.
// depends on cwss_pkg, cwss_cfg, cwss_step and the defines header
`include "coil_winding_step_sequencer_defines.svh"

module coil_winding_step_sequencer import cwss_pkg::*; #(
    parameter int unsigned STEPS_PER_TURN = 199
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic                  i_home_switch,
    input  logic                  i_fault_x,
    input  logic                  i_fault_r,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_spindle_step,
    output logic                  o_traverse_step,
    output logic                  o_traverse_dir,
    output logic [TURNS_W-1:0]    o_turns_left,
    output logic [1:0]            o_status,
    output logic                  o_finished
);

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_out_free;
    logic    w_advance;
    logic    w_take;

    cwss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cwss_step #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // pipeline handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_take     = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= '{func: i_func, home_switch: i_home_switch,
                        fault_x: i_fault_x, fault_r: i_fault_r};
        end
    end

    // sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.remaining_turns <= '0;
            r_state.spindle_count   <= COUNT_W'(STEPS_PER_TURN);
            r_state.traverse_count  <= '0;
            r_state.reversal_count  <= '0;
            r_state.direction       <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_spindle_step  = r_result.spindle_step;
    assign o_traverse_step = r_result.traverse_step;
    assign o_traverse_dir  = r_result.traverse_dir;
    assign o_turns_left    = r_result.turns_left;
    assign o_status        = r_result.status;
    assign o_finished      = r_result.finished;

    // a latched fault never clears without reset
    `CWSS_ASSERT_NEXT(a_fault_sticky, r_state.phase == PH_FAULT, r_state.phase == PH_FAULT)
    // a fault word carries no pulse and no turns
    `CWSS_ASSERT_NOW(a_fault_quiet, o_valid && o_status == ST_FAULT,
        o_turns_left == '0 && !o_spindle_step && !o_traverse_step)
    // the two motors never step in the same slot
    `CWSS_ASSERT_NOW(a_one_pulse, o_valid, !(o_spindle_step && o_traverse_step))
    // a finished run leaves the sequencer idle
    `CWSS_ASSERT_NOW(a_finish_idle, o_valid && o_finished, o_status == ST_IDLE)
    // a blocked word stays in the input register
    `CWSS_ASSERT_NEXT(a_hold_blocked, r_in_valid && !w_out_free, r_in_valid)

endmodule
